@@ hdl/mmq_pkg.sv @@
package mmq_pkg;

  localparam int NUM_MBX_DEF   = 16;
  localparam int POOL_SIZE_DEF = 64;
  localparam int DATA_W_DEF    = 64;

  localparam logic [2:0] ACT_ALLOC  = 3'd0;
  localparam logic [2:0] ACT_FREE   = 3'd1;
  localparam logic [2:0] ACT_SETPOL = 3'd2;
  localparam logic [2:0] ACT_SEND   = 3'd3;
  localparam logic [2:0] ACT_RECV   = 3'd4;
  localparam logic [2:0] ACT_PEEK   = 3'd5;

  localparam logic [1:0] POL_UNLIM  = 2'd0;
  localparam logic [1:0] POL_NEWEST = 2'd1;
  localparam logic [1:0] POL_OLDEST = 2'd2;

  localparam logic [6:0] DEF_LIMIT_RST  = 7'd8;
  localparam logic [1:0] DEF_POLICY_RST = 2'd1;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_MBX   = 4'd1,
    ST_NOT_ALLOC = 4'd2,
    ST_NO_BLK    = 4'd3,
    ST_Q_FULL    = 4'd4,
    ST_NO_MSG    = 4'd5,
    ST_NO_MBX    = 4'd6,
    ST_BAD_ARG   = 4'd7,
    ST_NOT_OWNER = 4'd8
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  mailbox;
    logic [7:0]  requester;
    logic [63:0] d1;
    logic [63:0] d2;
    logic [1:0]  pol;
    logic [6:0]  lim;
    logic        early;
    logic        report;
    status_t     err;
  } req_t;

endpackage

@@ hdl/mmq_ram.sv @@
module mmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ hdl/mmq_front.sv @@
module mmq_front #(
  parameter int NUM_MAILBOXES = mmq_pkg::NUM_MBX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    in_action,
  input  logic [7:0]    in_mailbox,
  input  logic [7:0]    in_requester,
  input  logic [63:0]   in_d1_in,
  input  logic [63:0]   in_d2_in,
  input  logic [1:0]    in_policy,
  input  logic [6:0]    in_queue_limit,
  output logic          fq_valid,
  output mmq_pkg::req_t fq_data,
  input  logic          fq_pop
);
  import mmq_pkg::*;

  req_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  req_t       cls;
  logic       do_push, do_pop;

  always_comb begin
    cls.action    = in_action;
    cls.mailbox   = in_mailbox;
    cls.requester = in_requester;
    cls.d1        = in_d1_in;
    cls.d2        = in_d2_in;
    cls.pol       = in_policy;
    cls.lim       = in_queue_limit;
    cls.early     = 1'b0;
    cls.report    = 1'b0;
    cls.err       = ST_OK;
    if (in_action > ACT_PEEK) begin
      cls.early = 1'b1;
      cls.err   = ST_BAD_ARG;
    end else if (in_action != ACT_ALLOC && 9'(in_mailbox) >= 9'(NUM_MAILBOXES)) begin
      cls.early = 1'b1;
      cls.err   = ST_BAD_MBX;
    end else if (in_action == ACT_SETPOL && in_policy > POL_OLDEST) begin
      cls.early  = 1'b1;
      cls.report = 1'b1;
      cls.err    = ST_BAD_ARG;
    end
  end

  assign full     = cnt_r == 2'd2;
  assign fq_valid = cnt_r != 2'd0;
  assign fq_data  = ent_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = fq_pop && fq_valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wp_r] <= cls;
    end
  end
endmodule

@@ hdl/mmq_back.sv @@
module mmq_back #(
  parameter int NUM_MAILBOXES = mmq_pkg::NUM_MBX_DEF,
  parameter int POOL_SIZE     = mmq_pkg::POOL_SIZE_DEF,
  parameter int DATA_WIDTH    = mmq_pkg::DATA_W_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fq_valid,
  input  mmq_pkg::req_t fq_data,
  output logic          fq_pop,
  input  logic [6:0]    def_limit,
  input  logic [1:0]    def_policy,
  output logic          empty,
  input  logic          pop,
  output logic [3:0]    out_status,
  output logic [7:0]    out_handle,
  output logic [63:0]   out_d1_out,
  output logic [63:0]   out_d2_out,
  output logic [6:0]    out_queued_count,
  output logic [31:0]   out_missed_count
);
  import mmq_pkg::*;

  localparam int BW  = $clog2(POOL_SIZE + 1);
  localparam int AW  = $clog2(POOL_SIZE);
  localparam int CW  = BW;
  localparam int MW  = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
  localparam int MFW = $clog2(NUM_MAILBOXES + 1);
  localparam int WW  = ((CW > 7) ? CW : 7) + 1;
  localparam int DW  = DATA_WIDTH;
  localparam logic [BW-1:0]  NIL_B = BW'(POOL_SIZE);
  localparam logic [MFW-1:0] NIL_M = MFW'(NUM_MAILBOXES);

  typedef struct packed {
    logic          alloc;
    logic [7:0]    owner;
    logic [BW-1:0] head;
    logic [BW-1:0] tail;
    logic [CW-1:0] cnt;
    logic [31:0]   miss;
    logic [6:0]    lim;
    logic [1:0]    pol;
  } mbrec_t;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_EXEC    = 12'b000000000010,
    S_TAKE    = 12'b000000000100,
    S_WALK_RD = 12'b000000001000,
    S_WALK_WT = 12'b000000010000,
    S_TRIM_RD = 12'b000000100000,
    S_TRIM    = 12'b000001000000,
    S_SEAL    = 12'b000010000000,
    S_APP     = 12'b000100000000,
    S_APP2    = 12'b001000000000,
    S_RD      = 12'b010000000000,
    S_DONE    = 12'b100000000000
  } state_t;

  state_t         st_r, st_nxt;
  req_t           req_r, req_nxt;
  mbrec_t         rec_r [NUM_MAILBOXES];
  logic [MFW-1:0] fnext_r [NUM_MAILBOXES];
  logic           nv_r [POOL_SIZE];
  logic [MFW-1:0] mfree_r, mfree_nxt;
  logic [BW-1:0]  bfree_r, bfree_nxt;
  logic [CW-1:0]  nfree_r, nfree_nxt;
  logic [BW-1:0]  blk_r, blk_nxt, ptr_r, ptr_nxt;
  logic [CW-1:0]  left_r, left_nxt, k_r, k_nxt;
  logic           trim_r, trim_nxt, knew_r, knew_nxt;
  status_t        sts_r, sts_nxt;
  logic [7:0]     hdl_r, hdl_nxt;
  logic [63:0]    d1_r, d1_nxt, d2_r, d2_nxt;
  logic           rep_r, rep_nxt;
  logic           ov_r, ov_nxt;
  logic [3:0]     os_r, os_nxt;
  logic [7:0]     oh_r, oh_nxt;
  logic [63:0]    od1_r, od1_nxt, od2_r, od2_nxt;
  logic [6:0]     oq_r, oq_nxt;
  logic [31:0]    om_r, om_nxt;

  logic [MW-1:0]  idx;
  mbrec_t         rec, rec_nxt;
  logic           rec_we, fn_we;
  logic           n_we, n_re, d_we, d_re;
  logic [BW-1:0]  n_wa, n_wd, n_ra, d_ra, d_wa;
  logic [BW-1:0]  n_q, nrd;
  logic [2*DW-1:0] d_q, d_wd;
  logic           nrv_r;
  logic [BW-1:0]  nra_r;
  logic [WW-1:0]  cnt_w, lim_w, nmiss;
  logic           over;
  logic [32:0]    msum;
  logic [31:0]    msat;

  assign idx = (req_r.action == ACT_ALLOC) ? MW'(mfree_r) : MW'(req_r.mailbox);
  assign rec = rec_r[idx];
  assign nrd = nrv_r ? n_q : BW'(nra_r + 1'b1);

  assign cnt_w = WW'(rec.cnt);
  assign lim_w = WW'(rec.lim);
  assign over  = (cnt_w + 1'b1) > lim_w;
  assign nmiss = cnt_w + 1'b1 - lim_w;
  assign msum  = 33'(rec.miss) + 33'(nmiss);
  assign msat  = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
  assign d_wd  = {req_r.d2[DW-1:0], req_r.d1[DW-1:0]};
  assign d_wa  = bfree_r;

  mmq_ram #(.WIDTH(BW), .DEPTH(POOL_SIZE)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa[AW-1:0]), .wdata(n_wd),
    .re(n_re), .raddr(n_ra[AW-1:0]), .rdata(n_q)
  );

  mmq_ram #(.WIDTH(2*DW), .DEPTH(POOL_SIZE)) u_data (
    .clk(clk), .we(d_we), .waddr(d_wa[AW-1:0]), .wdata(d_wd),
    .re(d_re), .raddr(d_ra[AW-1:0]), .rdata(d_q)
  );

  always_comb begin
    st_nxt    = st_r;
    req_nxt   = req_r;
    mfree_nxt = mfree_r;
    bfree_nxt = bfree_r;
    nfree_nxt = nfree_r;
    blk_nxt   = blk_r;
    ptr_nxt   = ptr_r;
    left_nxt  = left_r;
    k_nxt     = k_r;
    trim_nxt  = trim_r;
    knew_nxt  = knew_r;
    sts_nxt   = sts_r;
    hdl_nxt   = hdl_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    rep_nxt   = rep_r;
    ov_nxt    = ov_r;
    os_nxt    = os_r;
    oh_nxt    = oh_r;
    od1_nxt   = od1_r;
    od2_nxt   = od2_r;
    oq_nxt    = oq_r;
    om_nxt    = om_r;
    rec_nxt   = rec;
    rec_we    = 1'b0;
    fn_we     = 1'b0;
    fq_pop    = 1'b0;
    n_we      = 1'b0;
    n_wa      = rec.tail;
    n_wd      = bfree_r;
    n_re      = 1'b0;
    n_ra      = rec.head;
    d_we      = 1'b0;
    d_re      = 1'b0;
    d_ra      = rec.head;

    if (pop && ov_r) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (fq_valid) begin
          fq_pop  = 1'b1;
          req_nxt = fq_data;
          st_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        sts_nxt  = ST_OK;
        hdl_nxt  = 8'd0;
        d1_nxt   = 64'd0;
        d2_nxt   = 64'd0;
        rep_nxt  = 1'b0;
        trim_nxt = 1'b0;
        st_nxt   = S_DONE;
        if (req_r.early) begin
          sts_nxt = req_r.err;
          rep_nxt = req_r.report;
        end else if (req_r.action == ACT_ALLOC) begin
          if (mfree_r == NIL_M) begin
            sts_nxt = ST_NO_MBX;
          end else begin
            rec_we    = 1'b1;
            rec_nxt   = '{alloc: 1'b1, owner: req_r.requester, head: NIL_B, tail: NIL_B,
                          cnt: '0, miss: '0, lim: def_limit, pol: def_policy};
            mfree_nxt = fnext_r[idx];
            hdl_nxt   = 8'(mfree_r);
          end
        end else begin
          rep_nxt = 1'b1;
          if (!rec.alloc) begin
            sts_nxt = ST_NOT_ALLOC;
          end else if ((req_r.action == ACT_FREE || req_r.action == ACT_SETPOL) &&
                       rec.owner != req_r.requester && req_r.requester != 8'd0) begin
            sts_nxt = ST_NOT_OWNER;
          end else if (req_r.action == ACT_FREE) begin
            if (rec.cnt != '0) begin
              n_we      = 1'b1;
              bfree_nxt = rec.head;
              nfree_nxt = nfree_r + rec.cnt;
            end
            rec_we        = 1'b1;
            rec_nxt.head  = NIL_B;
            rec_nxt.tail  = NIL_B;
            rec_nxt.cnt   = '0;
            rec_nxt.alloc = 1'b0;
            rec_nxt.owner = 8'd0;
            fn_we         = 1'b1;
            mfree_nxt     = MFW'(idx);
          end else if (req_r.action == ACT_SETPOL) begin
            rec_we      = 1'b1;
            rec_nxt.pol = req_r.pol;
            rec_nxt.lim = req_r.lim;
          end else if (req_r.action == ACT_SEND) begin
            if (nfree_r == '0 || bfree_r >= NIL_B) begin
              sts_nxt = ST_NO_BLK;
            end else if ((rec.pol == POL_OLDEST && over) ||
                         (rec.pol == POL_NEWEST && rec.lim == 7'd0)) begin
              sts_nxt      = ST_Q_FULL;
              rec_we       = 1'b1;
              rec_nxt.miss = msat;
              if (rec.lim == 7'd0) begin
                if (rec.cnt != '0) begin
                  n_we      = 1'b1;
                  bfree_nxt = rec.head;
                  nfree_nxt = nfree_r + rec.cnt;
                end
                rec_nxt.head = NIL_B;
                rec_nxt.tail = NIL_B;
                rec_nxt.cnt  = '0;
              end else if (cnt_w > lim_w) begin
                ptr_nxt  = rec.head;
                left_nxt = CW'(rec.lim - 7'd1);
                knew_nxt = 1'b0;
                st_nxt   = (rec.lim == 7'd1) ? S_TRIM_RD : S_WALK_RD;
              end
            end else begin
              n_re = 1'b1;
              n_ra = bfree_r;
              d_we = 1'b1;
              st_nxt = S_TAKE;
              if (rec.pol == POL_NEWEST && over) begin
                sts_nxt      = ST_Q_FULL;
                rec_we       = 1'b1;
                rec_nxt.miss = msat;
                trim_nxt     = 1'b1;
                k_nxt        = CW'(nmiss);
              end
            end
          end else begin
            if (rec.cnt == '0 || rec.head >= NIL_B) begin
              sts_nxt = ST_NO_MSG;
            end else begin
              d_re   = 1'b1;
              n_re   = req_r.action == ACT_RECV;
              st_nxt = S_RD;
            end
          end
        end
      end
      S_TAKE: begin
        blk_nxt   = bfree_r;
        bfree_nxt = nrd;
        nfree_nxt = nfree_r - 1'b1;
        if (trim_r) begin
          ptr_nxt  = rec.head;
          left_nxt = k_r - 1'b1;
          knew_nxt = 1'b1;
          st_nxt   = (k_r == CW'(1)) ? S_TRIM_RD : S_WALK_RD;
        end else begin
          st_nxt = S_APP;
        end
      end
      S_WALK_RD: begin
        n_re   = 1'b1;
        n_ra   = ptr_r;
        st_nxt = S_WALK_WT;
      end
      S_WALK_WT: begin
        ptr_nxt  = nrd;
        left_nxt = left_r - 1'b1;
        st_nxt   = (left_r == CW'(1)) ? S_TRIM_RD : S_WALK_RD;
      end
      S_TRIM_RD: begin
        n_re   = 1'b1;
        n_ra   = ptr_r;
        st_nxt = S_TRIM;
      end
      S_TRIM: begin
        n_we   = 1'b1;
        rec_we = 1'b1;
        if (!knew_r) begin
          bfree_nxt    = nrd;
          nfree_nxt    = nfree_r + CW'(cnt_w - lim_w);
          rec_nxt.tail = ptr_r;
          rec_nxt.cnt  = CW'(rec.lim);
          st_nxt       = S_SEAL;
        end else begin
          n_wa         = ptr_r;
          bfree_nxt    = rec.head;
          nfree_nxt    = nfree_r + k_r;
          rec_nxt.cnt  = rec.cnt - k_r;
          rec_nxt.head = nrd;
          if (rec.cnt == k_r) begin
            rec_nxt.head = NIL_B;
            rec_nxt.tail = NIL_B;
          end
          st_nxt = S_APP;
        end
      end
      S_SEAL: begin
        n_we   = 1'b1;
        n_wa   = ptr_r;
        n_wd   = NIL_B;
        st_nxt = S_DONE;
      end
      S_APP: begin
        rec_we = 1'b1;
        if (rec.cnt != '0 && rec.tail < NIL_B) begin
          n_we = 1'b1;
          n_wd = blk_r;
        end else begin
          rec_nxt.head = blk_r;
        end
        rec_nxt.tail = blk_r;
        rec_nxt.cnt  = rec.cnt + 1'b1;
        st_nxt       = S_APP2;
      end
      S_APP2: begin
        n_we   = 1'b1;
        n_wa   = blk_r;
        n_wd   = NIL_B;
        st_nxt = S_DONE;
      end
      S_RD: begin
        d1_nxt = 64'($signed(d_q[DW-1:0]));
        d2_nxt = 64'($signed(d_q[2*DW-1:DW]));
        if (req_r.action == ACT_RECV) begin
          rec_we       = 1'b1;
          rec_nxt.head = nrd;
          rec_nxt.cnt  = rec.cnt - 1'b1;
          if (rec.cnt == CW'(1)) begin
            rec_nxt.head = NIL_B;
            rec_nxt.tail = NIL_B;
          end
          n_we      = 1'b1;
          n_wa      = rec.head;
          bfree_nxt = rec.head;
          nfree_nxt = nfree_r + 1'b1;
        end
        st_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || pop) begin
          ov_nxt  = 1'b1;
          os_nxt  = sts_r;
          oh_nxt  = hdl_r;
          od1_nxt = d1_r;
          od2_nxt = d2_r;
          oq_nxt  = rep_r ? 7'(rec.cnt) : 7'd0;
          om_nxt  = rep_r ? rec.miss : 32'd0;
          st_nxt  = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ov_r    <= 1'b0;
      mfree_r <= '0;
      bfree_r <= '0;
      nfree_r <= CW'(POOL_SIZE);
      nrv_r   <= 1'b0;
      for (int i = 0; i < NUM_MAILBOXES; i++) begin
        rec_r[i]   <= '{alloc: 1'b0, owner: 8'd0, head: NIL_B, tail: NIL_B,
                        cnt: '0, miss: '0, lim: 7'd0, pol: POL_UNLIM};
        fnext_r[i] <= MFW'(i + 1);
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
        nv_r[i] <= 1'b0;
      end
    end else begin
      st_r    <= st_nxt;
      ov_r    <= ov_nxt;
      mfree_r <= mfree_nxt;
      bfree_r <= bfree_nxt;
      nfree_r <= nfree_nxt;
      if (rec_we) begin
        rec_r[idx] <= rec_nxt;
      end
      if (fn_we) begin
        fnext_r[idx] <= mfree_r;
      end
      if (n_we) begin
        nv_r[n_wa[AW-1:0]] <= 1'b1;
      end
      if (n_re) begin
        nrv_r <= nv_r[n_ra[AW-1:0]];
      end
    end
    if (n_re) begin
      nra_r <= n_ra;
    end
    req_r  <= req_nxt;
    blk_r  <= blk_nxt;
    ptr_r  <= ptr_nxt;
    left_r <= left_nxt;
    k_r    <= k_nxt;
    trim_r <= trim_nxt;
    knew_r <= knew_nxt;
    sts_r  <= sts_nxt;
    hdl_r  <= hdl_nxt;
    d1_r   <= d1_nxt;
    d2_r   <= d2_nxt;
    rep_r  <= rep_nxt;
    os_r   <= os_nxt;
    oh_r   <= oh_nxt;
    od1_r  <= od1_nxt;
    od2_r  <= od2_nxt;
    oq_r   <= oq_nxt;
    om_r   <= om_nxt;
  end

  assign empty            = !ov_r;
  assign out_status       = os_r;
  assign out_handle       = oh_r;
  assign out_d1_out       = od1_r;
  assign out_d2_out       = od2_r;
  assign out_queued_count = oq_r;
  assign out_missed_count = om_r;
endmodule

@@ hdl/mailbox_message_queue_core.sv @@
// Mailbox message queue core.
// Requests enter through a queue-style port: a request is taken on a clock
// edge with push high and full low. A two-entry request queue holds checked
// requests until the execution engine is free.
// Results leave through an output register: the oldest result is valid while
// empty is low and is taken on an edge with pop high. While a result waits,
// the engine holds its next result and new requests fill the request queue
// until full rises.
// Checks, allocate, free, set policy and a send dropped on a full keep-oldest
// queue or a limit of 0 end in the execute state; receive and peek add a read
// state; a plain send appends a free block. A keep-newest send that drops k
// head messages walks to the k-th block; a keep-oldest send that trims the
// tail to limit L walks to block L. One request is in the engine at a time,
// so a new request starts once the previous one has left the engine.
// Config registers via APB: 0x0 default queue limit, 0x4 default policy;
// write only while idle.
// Reset (synchronous, rst_n low) frees all mailboxes and message blocks;
// link memory entries read as their reset chain until first written.
module mailbox_message_queue_core #(
  parameter int NUM_MAILBOXES = mmq_pkg::NUM_MBX_DEF,
  parameter int POOL_SIZE     = mmq_pkg::POOL_SIZE_DEF,
  parameter int DATA_WIDTH    = mmq_pkg::DATA_W_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_mailbox,
  input  logic [7:0]  in_requester,
  input  logic [63:0] in_d1_in,
  input  logic [63:0] in_d2_in,
  input  logic [1:0]  in_policy,
  input  logic [6:0]  in_queue_limit,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_status,
  output logic [7:0]  out_handle,
  output logic [63:0] out_d1_out,
  output logic [63:0] out_d2_out,
  output logic [6:0]  out_queued_count,
  output logic [31:0] out_missed_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mmq_pkg::*;

  logic [6:0] dlim_r;
  logic [1:0] dpol_r;
  logic       fq_valid, fq_pop;
  req_t       fq_data;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {30'd0, dpol_r} : {25'd0, dlim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlim_r <= DEF_LIMIT_RST;
      dpol_r <= DEF_POLICY_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        dpol_r <= pwdata[1:0];
      end else begin
        dlim_r <= pwdata[6:0];
      end
    end
  end

  mmq_front #(.NUM_MAILBOXES(NUM_MAILBOXES)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_action(in_action), .in_mailbox(in_mailbox), .in_requester(in_requester),
    .in_d1_in(in_d1_in), .in_d2_in(in_d2_in), .in_policy(in_policy),
    .in_queue_limit(in_queue_limit),
    .fq_valid(fq_valid), .fq_data(fq_data), .fq_pop(fq_pop)
  );

  mmq_back #(
    .NUM_MAILBOXES(NUM_MAILBOXES), .POOL_SIZE(POOL_SIZE), .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .fq_valid(fq_valid), .fq_data(fq_data), .fq_pop(fq_pop),
    .def_limit(dlim_r), .def_policy(dpol_r),
    .empty(empty), .pop(pop),
    .out_status(out_status), .out_handle(out_handle),
    .out_d1_out(out_d1_out), .out_d2_out(out_d2_out),
    .out_queued_count(out_queued_count), .out_missed_count(out_missed_count)
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> fq_valid)
    else $error("request taken from empty queue");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> fq_valid)
    else $error("accepted request not queued");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |=> !fq_pop)
    else $error("engine took two requests back to back");
endmodule

@@ tb/sv/mailbox_message_queue_core_checker.sv @@
module mailbox_message_queue_core_checker #(
  parameter logic [2:0] LIMIT_ADDR  = 3'd0,
  parameter logic [2:0] POLICY_ADDR = 3'd4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_mailbox,
  input  logic [7:0]  in_requester,
  input  logic [63:0] in_d1_in,
  input  logic [63:0] in_d2_in,
  input  logic [1:0]  in_policy,
  input  logic [6:0]  in_queue_limit,
  input  logic        empty,
  input  logic        pop,
  input  logic [3:0]  out_status,
  input  logic [7:0]  out_handle,
  input  logic [63:0] out_d1_out,
  input  logic [63:0] out_d2_out,
  input  logic [6:0]  out_queued_count,
  input  logic [31:0] out_missed_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending
);
  import mmq_pkg::*;

  localparam int NMBX  = NUM_MBX_DEF;
  localparam int NBLK  = POOL_SIZE_DEF;
  localparam logic [31:0] MISS_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic [3:0]  status;
    logic [7:0]  handle;
    logic [63:0] d1;
    logic [63:0] d2;
    logic [6:0]  queued;
    logic [31:0] missed;
  } mbx_reply_t;

  mbx_reply_t  reply_q[$];

  logic        mb_used[NMBX];
  logic [7:0]  mb_owner[NMBX];
  int          mb_head[NMBX];
  int          mb_tail[NMBX];
  int          mb_cnt[NMBX];
  logic [31:0] mb_missed[NMBX];
  int          mb_lim[NMBX];
  logic [1:0]  mb_pol[NMBX];
  int          mb_fnext[NMBX];
  int          mb_fhead;
  int          blk_next[NBLK];
  logic [63:0] blk_w1[NBLK];
  logic [63:0] blk_w2[NBLK];
  int          blk_fhead;
  int          blk_free;
  logic [6:0]  def_lim;
  logic [1:0]  def_pol;

  function automatic void clear_state();
    for (int i = 0; i < NMBX; i++) begin
      mb_used[i] = 1'b0; mb_owner[i] = '0; mb_head[i] = NBLK; mb_tail[i] = NBLK;
      mb_cnt[i] = 0; mb_missed[i] = '0; mb_lim[i] = 0; mb_pol[i] = POL_UNLIM;
      mb_fnext[i] = i + 1;
    end
    mb_fhead = 0;
    for (int i = 0; i < NBLK; i++) begin
      blk_next[i] = i + 1; blk_w1[i] = '0; blk_w2[i] = '0;
    end
    blk_fhead = 0;
    blk_free = NBLK;
    def_lim = DEF_LIMIT_RST;
    def_pol = DEF_POLICY_RST;
  endfunction

  function automatic void free_blk(int b);
    if (b >= NBLK) return;
    blk_next[b] = blk_fhead;
    blk_fhead = b;
    blk_free++;
  endfunction

  function automatic void note_miss(int m);
    if (mb_missed[m] != MISS_MAX) mb_missed[m]++;
  endfunction

  function automatic int unlink_head(int m);
    int b;
    b = mb_head[m];
    if (mb_cnt[m] == 0 || b >= NBLK) return NBLK;
    mb_cnt[m]--;
    mb_head[m] = blk_next[b];
    if (mb_cnt[m] == 0) begin
      mb_head[m] = NBLK;
      mb_tail[m] = NBLK;
    end
    return b;
  endfunction

  function automatic void cut_tail(int m);
    int p, old;
    if (mb_cnt[m] == 0) return;
    old = mb_tail[m];
    if (mb_cnt[m] == 1) begin
      mb_head[m] = NBLK;
      mb_tail[m] = NBLK;
    end else begin
      p = mb_head[m];
      for (int i = 2; i < mb_cnt[m] && p < NBLK; i++) p = blk_next[p];
      if (p < NBLK) begin
        blk_next[p] = NBLK;
        mb_tail[m] = p;
      end
    end
    mb_cnt[m]--;
    free_blk(old);
    note_miss(m);
  endfunction

  function automatic logic [3:0] enqueue_blk(int m, int b);
    logic [3:0] st;
    st = ST_OK;
    if (mb_pol[m] == POL_NEWEST) begin
      while (mb_cnt[m] != 0 && mb_cnt[m] + 1 > mb_lim[m]) begin
        free_blk(unlink_head(m));
        note_miss(m);
        st = ST_Q_FULL;
      end
      if (mb_lim[m] == 0) begin
        free_blk(b);
        note_miss(m);
        return ST_Q_FULL;
      end
    end else if (mb_pol[m] == POL_OLDEST) begin
      if (mb_cnt[m] + 1 > mb_lim[m]) begin
        free_blk(b);
        note_miss(m);
        while (mb_cnt[m] > mb_lim[m]) cut_tail(m);
        return ST_Q_FULL;
      end
    end
    if (mb_cnt[m] != 0 && mb_tail[m] < NBLK) blk_next[mb_tail[m]] = b;
    else mb_head[m] = b;
    mb_tail[m] = b;
    blk_next[b] = NBLK;
    mb_cnt[m]++;
    return st;
  endfunction

  function automatic mbx_reply_t mailbox_outcome(logic [2:0] act, logic [7:0] mbx,
      logic [7:0] req, logic [63:0] w1, logic [63:0] w2, logic [1:0] pl, logic [6:0] lm);
    mbx_reply_t r;
    int m, b;
    r = '{ST_OK, 8'd0, 64'd0, 64'd0, 7'd0, 32'd0};
    if (act > ACT_PEEK) begin
      r.status = ST_BAD_ARG;
      return r;
    end
    if (act == ACT_ALLOC) begin
      if (mb_fhead >= NMBX) begin
        r.status = ST_NO_MBX;
        return r;
      end
      m = mb_fhead;
      mb_fhead = mb_fnext[m];
      mb_used[m] = 1'b1; mb_owner[m] = req; mb_head[m] = NBLK; mb_tail[m] = NBLK;
      mb_cnt[m] = 0; mb_missed[m] = '0; mb_lim[m] = def_lim; mb_pol[m] = def_pol;
      r.handle = m[7:0];
      return r;
    end
    if (mbx >= NMBX) begin
      r.status = ST_BAD_MBX;
      return r;
    end
    m = mbx;
    if (act == ACT_SETPOL && pl > POL_OLDEST) r.status = ST_BAD_ARG;
    else if (!mb_used[m]) r.status = ST_NOT_ALLOC;
    else if ((act == ACT_FREE || act == ACT_SETPOL) && mb_owner[m] != req && req != 0)
      r.status = ST_NOT_OWNER;
    else if (act == ACT_FREE) begin
      while (mb_cnt[m] != 0) free_blk(unlink_head(m));
      mb_head[m] = NBLK; mb_tail[m] = NBLK;
      mb_used[m] = 1'b0; mb_owner[m] = '0;
      mb_fnext[m] = mb_fhead;
      mb_fhead = m;
    end else if (act == ACT_SETPOL) begin
      mb_pol[m] = pl;
      mb_lim[m] = lm;
    end else if (act == ACT_SEND) begin
      if (blk_free == 0 || blk_fhead >= NBLK) r.status = ST_NO_BLK;
      else begin
        b = blk_fhead;
        blk_fhead = blk_next[b];
        blk_free--;
        blk_w1[b] = w1;
        blk_w2[b] = w2;
        r.status = enqueue_blk(m, b);
      end
    end else begin
      if (act == ACT_RECV) b = unlink_head(m);
      else b = (mb_cnt[m] != 0) ? mb_head[m] : NBLK;
      if (b >= NBLK) r.status = ST_NO_MSG;
      else begin
        r.d1 = blk_w1[b];
        r.d2 = blk_w2[b];
        if (act == ACT_RECV) free_blk(b);
      end
    end
    r.queued = mb_cnt[m][6:0];
    r.missed = mb_missed[m];
    return r;
  endfunction

  initial begin
    fails = 0;
    clear_state();
  end

  assign pending = reply_q.size();

  always @(posedge clk) begin
    mbx_reply_t e;
    if (!rst_n) begin
      clear_state();
      reply_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == LIMIT_ADDR) def_lim = pwdata[6:0];
        else if (paddr == POLICY_ADDR) def_pol = pwdata[1:0];
      end
      if (push && !full)
        reply_q.push_back(mailbox_outcome(in_action, in_mailbox, in_requester,
                                          in_d1_in, in_d2_in, in_policy, in_queue_limit));
      if (pop && !empty) begin
        if (reply_q.size() == 0) begin
          $error("result with no request waiting: status %0d", out_status);
          fails++;
        end else begin
          e = reply_q.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d act %0d", e.status, out_status); fails++;
          end
          if (out_handle !== e.handle) begin
            $error("handle exp %0d act %0d", e.handle, out_handle); fails++;
          end
          if (out_d1_out !== e.d1) begin
            $error("d1_out exp %h act %h", e.d1, out_d1_out); fails++;
          end
          if (out_d2_out !== e.d2) begin
            $error("d2_out exp %h act %h", e.d2, out_d2_out); fails++;
          end
          if (out_queued_count !== e.queued) begin
            $error("queued_count exp %0d act %0d", e.queued, out_queued_count); fails++;
          end
          if (out_missed_count !== e.missed) begin
            $error("missed_count exp %0d act %0d", e.missed, out_missed_count); fails++;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/mailbox_message_queue_core_test.sv @@
module mailbox_message_queue_core_test;
  import mmq_pkg::*;

  localparam logic [2:0] LIMIT_ADDR  = 3'd0;
  localparam logic [2:0] POLICY_ADDR = 3'd4;
  localparam int         PER_PHASE   = 193;
  localparam int         MAX_CYCLES  = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  in_action = '0;
  logic [7:0]  in_mailbox = '0;
  logic [7:0]  in_requester = '0;
  logic [63:0] in_d1_in = '0;
  logic [63:0] in_d2_in = '0;
  logic [1:0]  in_policy = '0;
  logic [6:0]  in_queue_limit = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  out_status;
  logic [7:0]  out_handle;
  logic [63:0] out_d1_out;
  logic [63:0] out_d2_out;
  logic [6:0]  out_queued_count;
  logic [31:0] out_missed_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fails;
  int          pending;
  int          tx_idle = 7;
  int          rx_idle = 63;
  int          sent = 0;
  int          cycles = 0;

  always #10 clk = ~clk;

  mailbox_message_queue_core u_top (.*);

  mailbox_message_queue_core_checker #(.LIMIT_ADDR(LIMIT_ADDR), .POLICY_ADDR(POLICY_ADDR))
    u_check (.*);

  always @(posedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("mailbox_message_queue_core verification failed");
      $finish;
    end
  end

  task automatic put(logic [2:0] act, logic [7:0] mbx, logic [7:0] req,
                     logic [63:0] w1, logic [63:0] w2, logic [1:0] pl, logic [6:0] lm);
    in_action <= act; in_mailbox <= mbx; in_requester <= req;
    in_d1_in <= w1; in_d2_in <= w2; in_policy <= pl; in_queue_limit <= lm;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sent++;
    if (sent < 450) begin
      tx_idle = 7; rx_idle = 63;
    end else if (sent < 900) begin
      tx_idle = 63; rx_idle = 7;
    end else begin
      tx_idle = 0; rx_idle = 0;
    end
    if ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '1;
      3: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic rand_req();
    int r;
    logic [2:0] act;
    logic [7:0] mbx, req;
    logic [6:0] lm;
    r = $urandom_range(99);
    if (r < 10) act = ACT_ALLOC;
    else if (r < 16) act = ACT_FREE;
    else if (r < 24) act = ACT_SETPOL;
    else if (r < 60) act = ACT_SEND;
    else if (r < 80) act = ACT_RECV;
    else if (r < 97) act = ACT_PEEK;
    else act = 3'($urandom_range(6, 7));
    mbx = ($urandom_range(9) != 0) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    r = $urandom_range(99);
    req = (r < 40) ? 8'd0 : (r < 85) ? 8'($urandom_range(1, 3)) : 8'($urandom_range(255));
    lm = ($urandom_range(4) != 0) ? 7'($urandom_range(8)) : 7'($urandom_range(127));
    put(act, mbx, req, rand_word(), rand_word(), 2'($urandom_range(3)), lm);
  endtask

  initial begin
    int lims[7];
    int pols[7];
    lims = '{8, 0, 64, 127, 1, 3, 64};
    pols = '{1, 2, 0, 3, 1, 0, 2};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put(ACT_ALLOC, 8'd0, 8'd5, '0, '0, POL_UNLIM, 7'd0);
    put(ACT_SEND, 8'd0, 8'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, '0, '0);
    put(ACT_SEND, 8'd0, 8'd255, '1, '0, '0, '0);
    put(ACT_PEEK, 8'd0, 8'd0, '0, '0, '0, '0);
    put(ACT_RECV, 8'd0, 8'd0, '0, '0, '0, '0);
    put(ACT_RECV, 8'd0, 8'd0, '0, '0, '0, '0);
    put(ACT_RECV, 8'd0, 8'd0, '0, '0, '0, '0);
    put(ACT_PEEK, 8'd0, 8'd0, '0, '0, '0, '0);
    put(ACT_SETPOL, 8'd0, 8'd5, '0, '0, 2'd3, 7'd4);
    put(ACT_SETPOL, 8'd0, 8'd6, '0, '0, POL_OLDEST, 7'd1);
    put(ACT_SETPOL, 8'd0, 8'd5, '0, '0, POL_OLDEST, 7'd1);
    put(ACT_SEND, 8'd0, 8'd0, 64'd1, 64'd2, '0, '0);
    put(ACT_SEND, 8'd0, 8'd0, 64'd3, 64'd4, '0, '0);
    put(ACT_SETPOL, 8'd0, 8'd0, '0, '0, POL_OLDEST, 7'd0);
    put(ACT_SEND, 8'd0, 8'd0, 64'd5, 64'd6, '0, '0);
    put(ACT_SETPOL, 8'd0, 8'd0, '0, '0, POL_NEWEST, 7'd0);
    put(ACT_SEND, 8'd0, 8'd0, 64'd7, 64'd8, '0, '0);
    put(ACT_SETPOL, 8'd0, 8'd0, '0, '0, POL_NEWEST, 7'd127);
    put(ACT_FREE, 8'd0, 8'd9, '0, '0, '0, '0);
    put(ACT_FREE, 8'd0, 8'd0, '0, '0, '0, '0);
    put(ACT_SEND, 8'd0, 8'd0, '0, '0, '0, '0);
    put(ACT_SEND, 8'd255, 8'd0, '0, '0, '0, '0);
    put(3'd6, 8'd0, 8'd0, '0, '0, '0, '0);
    put(3'd7, 8'd255, 8'd255, '1, '1, 2'd3, 7'd127);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      cfg_write(LIMIT_ADDR, 32'(lims[ph]));
      cfg_write(POLICY_ADDR, 32'(pols[ph]));
      for (int i = 0; i < PER_PHASE; i++) rand_req();
      drain();
    end

    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("mailbox_message_queue_core verification clean");
    else
      $display("mailbox_message_queue_core verification failed");
    $finish;
  end

endmodule

@@ mailbox_message_queue_core.f @@
hdl/mmq_pkg.sv
hdl/mmq_ram.sv
hdl/mmq_front.sv
hdl/mmq_back.sv
hdl/mailbox_message_queue_core.sv
tb/sv/mailbox_message_queue_core_checker.sv
tb/sv/mailbox_message_queue_core_test.sv
